/* src/hpack_huffman_decoder_top_defines.svh */
// Assertion macros for the HPACK Huffman decoder.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef HPACK_HUFFMAN_DECODER_TOP_DEFINES_SVH
`define HPACK_HUFFMAN_DECODER_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define HHD_ASSERT_ALWAYS(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("hhd assertion failed");
// next-cycle implication
`define HHD_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("hhd assertion failed");
`else
`define HHD_ASSERT_ALWAYS(label, clk_s, rst_s, ante, cons)
`define HHD_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)
`endif

`endif

/* src/hhd_pkg.sv */
// Shared types and constants of the HPACK Huffman decoder.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package hhd_pkg;

    // result status codes
    localparam logic [1:0] STATUS_SYMBOL = 2'd0;
    localparam logic [1:0] STATUS_OK     = 2'd1;
    localparam logic [1:0] STATUS_EOS    = 2'd2;
    localparam logic [1:0] STATUS_TRUNC  = 2'd3;

    // source of the next pending result
    typedef enum logic [1:0] {
        PEND_LEAF  = 2'd0,
        PEND_OK    = 2'd1,
        PEND_TRUNC = 2'd2
    } pend_sel_t;

    // controller -> datapath
    typedef struct packed {
        logic      load_byte;  // take a new encoded byte
        logic      drop_byte;  // byte dropped while discarding
        logic      advance;    // consume one bit of the byte
        logic      load_pend;  // place a new result in the pending slot
        pend_sel_t pend_sel;
        logic      flush;      // send pending result as last of the byte
        logic      set_disc;   // enter discard mode
        logic      node_clr;   // return walk to the root
    } hhd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic leaf;        // current bit reaches a leaf
        logic eos;         // that leaf is EOS
        logic rest_ones;   // bits after the current one are all ones
        logic last_bit;    // current bit is the last of the byte
        logic fin;         // byte is the final one of the string
        logic pend_valid;  // pending slot holds a result
        logic out_free;    // output register can take a result now
        logic discarding;
    } hhd_status_t;

endpackage

/* src/hhd_in_if.sv */
// Input channel of the HPACK Huffman decoder: one encoded byte per item.
// No dependencies.
`timescale 1ns / 1ps

interface hhd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

/* src/hhd_out_if.sv */
// Output channel of the HPACK Huffman decoder: one decoded result per item.
// No dependencies.
`timescale 1ns / 1ps

interface hhd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic [1:0] status;
    logic       run_end;

    modport source (output valid, output symbol, output status, output run_end, input ready);
    modport sink   (input valid, input symbol, input status, input run_end, output ready);
endinterface

/* src/hhd_rom.sv */
// Huffman tree ROM, 256 entries, registered read data.
// Entry: [31:16] 0-child, [15:0] 1-child; bit 15 of a child marks a leaf.
`timescale 1ns / 1ps

module hhd_rom
(
    input  logic        clk,
    input  logic [7:0]  addr,
    output logic [31:0] q
);

    localparam logic [31:0] TREE_ROM [256] = '{
        32'd65538, 32'd196612, 32'd983056, 32'd327686, 32'd524297,
        32'd2150662193, 32'd2150760455, 32'd2149613615, 32'd655371, 32'd786445,
        32'd2150858849, 32'd2154004581, 32'd2154397807, 32'd2155085838, 32'd2149941294,
        32'd1114130, 32'd2031648, 32'd1245204, 32'd1638426, 32'd1376278,
        32'd1507352, 32'd2150924341, 32'd2151055415, 32'd2151186489, 32'd2151317565,
        32'd1769500, 32'd1900574, 32'd2153021540, 32'd2154266728, 32'd2154594413,
        32'd2154725488, 32'd2162722, 32'd2949166, 32'd2293796, 32'd2555944,
        32'd2154987635, 32'd2424870, 32'd2150006828, 32'd2150465601, 32'd2687018,
        32'd2818092, 32'd2151972934, 32'd2152169549, 32'd2152628307, 32'd2153742434,
        32'd3080240, 32'd3604536, 32'd3211314, 32'd3342388, 32'd2154201205,
        32'd2155249783, 32'd2155380857, 32'd3473462, 32'd2151383106, 32'd2151907397,
        32'd3735610, 32'd4128832, 32'd3866684, 32'd3997758, 32'd2152300623,
        32'd2152759381, 32'd2153283690, 32'd2154528890, 32'd4259906, 32'd4653128,
        32'd4390980, 32'd4522054, 32'd2149744681, 32'd2152235082, 32'd2152431692,
        32'd2152824914, 32'd4784202, 32'd4915276, 32'd2153152599, 32'd2153349210,
        32'd2154889293, 32'd5111887, 32'd2150137898, 32'd2150334527, 32'd5242961,
        32'd2153480285, 32'd5374035, 32'd2155643006, 32'd5505109, 32'd2149679143,
        32'd5636183, 32'd2149810270, 32'd5767257, 32'd2149875774, 32'd2151678042,
        32'd5963868, 32'd2151448699, 32'd2155675741, 32'd2153775198, 32'd6226016,
        32'd6357090, 32'd10420384, 32'd6488164, 32'd8454274, 32'd6619238,
        32'd7536756, 32'd6750312, 32'd7143534, 32'd6881386, 32'd7012460,
        32'd2158264485, 32'd2158395559, 32'd2158526633, 32'd2158657707, 32'd7274608,
        32'd7405682, 32'd2158788781, 32'd2158919855, 32'd2159050929, 32'd2159182003,
        32'd7667830, 32'd8061052, 32'd7798904, 32'd7929978, 32'd2159313077,
        32'd2159444151, 32'd2159575225, 32'd2159706299, 32'd8192126, 32'd8323200,
        32'd2159837373, 32'd2159968447, 32'd2160099521, 32'd2160230595, 32'd8585348,
        32'd9502866, 32'd8716422, 32'd9109644, 32'd8847496, 32'd8978570,
        32'd2160361669, 32'd2160492743, 32'd2160623817, 32'd2160754891, 32'd9240718,
        32'd9371792, 32'd2160885965, 32'd2161017039, 32'd2161148113, 32'd2161279187,
        32'd9633940, 32'd10027162, 32'd9765014, 32'd9896088, 32'd2161410261,
        32'd2161541335, 32'd2161672409, 32'd2161803483, 32'd10158236, 32'd10289310,
        32'd2161934557, 32'd2162065631, 32'd2162196705, 32'd2162327779, 32'd10551458,
        32'd12714179, 32'd10682532, 32'd11600050, 32'd10813606, 32'd11206828,
        32'd10944680, 32'd11075754, 32'd2162458853, 32'd2162589927, 32'd2162721001,
        32'd2162852075, 32'd11337902, 32'd11468976, 32'd2162983149, 32'd2163114223,
        32'd2163245297, 32'd2163376371, 32'd11731124, 32'd12124346, 32'd11862198,
        32'd11993272, 32'd2163507445, 32'd2163638519, 32'd2163769593, 32'd2163900667,
        32'd12255420, 32'd12386494, 32'd2164031741, 32'd2164162815, 32'd2164261055,
        32'd12583105, 32'd2147516417, 32'd2147647491, 32'd2147778565, 32'd12845253,
        32'd14811363, 32'd12976327, 32'd13893845, 32'd13107401, 32'd13500623,
        32'd13238475, 32'd13369549, 32'd2147909639, 32'd2148040713, 32'd2148171787,
        32'd2148302861, 32'd13631697, 32'd13762771, 32'd2148433935, 32'd2148565009,
        32'd2148696083, 32'd2148827157, 32'd14024919, 32'd14418141, 32'd14155993,
        32'd14287067, 32'd2148958231, 32'd2149089305, 32'd2149220379, 32'd2149351453,
        32'd14549215, 32'd14680289, 32'd2149482527, 32'd2153545855, 32'd2155905153,
        32'd2156036227, 32'd14942437, 32'd15859955, 32'd15073511, 32'd15466733,
        32'd15204585, 32'd15335659, 32'd2156167301, 32'd2156298375, 32'd2156429449,
        32'd2156560523, 32'd15597807, 32'd15728881, 32'd2156691597, 32'd2156822671,
        32'd2156953745, 32'd2157084819, 32'd15991029, 32'd16384251, 32'd16122103,
        32'd16253177, 32'd2157215893, 32'd2157346967, 32'd2157478041, 32'd2157609115,
        32'd16515325, 32'd16646399, 32'd2157740189, 32'd2157871263, 32'd2158002337,
        32'd2158133411
    };

    // synchronous read
    always_ff @(posedge clk)
    begin
        q <= TREE_ROM[addr];
    end

endmodule

/* src/hhd_datapath.sv */
// Datapath of the HPACK Huffman decoder: byte shifter, tree walk, pending
// result slot and output register. Depends on hhd_pkg and hhd_rom.
`timescale 1ns / 1ps

module hhd_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          data_byte,
    input  logic                final_byte,
    input  hhd_pkg::hhd_cmd_t   cmd,
    output hhd_pkg::hhd_status_t st,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [7:0]          symbol,
    output logic [1:0]          status,
    output logic                run_end
);

    logic [7:0]  byte_reg, byte_next;
    logic        fin_reg, fin_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [7:0]  node_reg, node_next;
    logic        disc_reg, disc_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [7:0]  pend_sym_reg, pend_sym_next;
    logic [1:0]  pend_status_reg, pend_status_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_sym_reg, out_sym_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic        out_run_end_reg, out_run_end_next;

    logic [31:0] rom_q;
    logic [15:0] child;
    logic        leaf;
    logic        eos;
    logic        push;
    logic        out_free;

    // tree ROM, addressed with the next node so the entry is ready each cycle
    hhd_rom u_rom
    (
        .clk  (clk),
        .addr (node_next),
        .q    (rom_q)
    );

    // child selected by the current (top) bit
    assign child    = byte_reg[7] ? rom_q[15:0] : rom_q[31:16];
    assign leaf     = child[15];
    assign eos      = |child[14:8];
    assign out_free = !out_valid_reg || out_ready;
    assign push     = (cmd.load_pend && pend_valid_reg) || cmd.flush;

    assign st.leaf       = leaf;
    assign st.eos        = eos;
    assign st.rest_ones  = &byte_reg[6:0];
    assign st.last_bit   = (cnt_reg == 3'd0);
    assign st.fin        = fin_reg;
    assign st.pend_valid = pend_valid_reg;
    assign st.out_free   = out_free;
    assign st.discarding = disc_reg;

    // byte shifter: shifts in ones so the remaining-bits test is a reduction
    always_comb
    begin
        byte_next = byte_reg;
        fin_next  = fin_reg;
        cnt_next  = cnt_reg;
        if (cmd.load_byte)
        begin
            byte_next = data_byte;
            fin_next  = final_byte;
            cnt_next  = 3'd7;
        end
        else if (cmd.advance)
        begin
            byte_next = {byte_reg[6:0], 1'b1};
            cnt_next  = cnt_reg - 3'd1;
        end
    end

    // tree walk and discard mode
    always_comb
    begin
        node_next = node_reg;
        disc_next = disc_reg;
        if (cmd.node_clr || (cmd.drop_byte && final_byte))
        begin
            node_next = 8'd0;
        end
        else if (cmd.advance)
        begin
            node_next = leaf ? 8'd0 : child[7:0];
        end
        if (cmd.set_disc)
        begin
            disc_next = 1'b1;
        end
        else if (cmd.drop_byte && final_byte)
        begin
            disc_next = 1'b0;
        end
    end

    // pending slot: a result waits here until it is known whether it ends the byte
    always_comb
    begin
        pend_valid_next  = pend_valid_reg;
        pend_sym_next    = pend_sym_reg;
        pend_status_next = pend_status_reg;
        if (cmd.load_pend)
        begin
            pend_valid_next = 1'b1;
            case (cmd.pend_sel)
                hhd_pkg::PEND_LEAF:
                begin
                    pend_sym_next    = eos ? 8'd0 : child[7:0];
                    pend_status_next = eos ? hhd_pkg::STATUS_EOS : hhd_pkg::STATUS_SYMBOL;
                end
                hhd_pkg::PEND_OK:
                begin
                    pend_sym_next    = 8'd0;
                    pend_status_next = hhd_pkg::STATUS_OK;
                end
                hhd_pkg::PEND_TRUNC:
                begin
                    pend_sym_next    = 8'd0;
                    pend_status_next = hhd_pkg::STATUS_TRUNC;
                end
                default:
                begin
                    pend_sym_next    = 8'd0;
                    pend_status_next = hhd_pkg::STATUS_TRUNC;
                end
            endcase
        end
        else if (cmd.flush)
        begin
            pend_valid_next = 1'b0;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_sym_next     = out_sym_reg;
        out_status_next  = out_status_reg;
        out_run_end_next = out_run_end_reg;
        if (push)
        begin
            out_valid_next   = 1'b1;
            out_sym_next     = pend_sym_reg;
            out_status_next  = pend_status_reg;
            out_run_end_next = cmd.flush;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= 3'd0;
            node_reg       <= 8'd0;
            disc_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            node_reg       <= node_next;
            disc_reg       <= disc_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        byte_reg        <= byte_next;
        fin_reg         <= fin_next;
        pend_sym_reg    <= pend_sym_next;
        pend_status_reg <= pend_status_next;
        out_sym_reg     <= out_sym_next;
        out_status_reg  <= out_status_next;
        out_run_end_reg <= out_run_end_next;
    end

    assign out_valid = out_valid_reg;
    assign symbol    = out_sym_reg;
    assign status    = out_status_reg;
    assign run_end   = out_run_end_reg;

endmodule

/* src/hhd_ctrl.sv */
// Controller of the HPACK Huffman decoder: sequences one byte bit by bit and
// orders the results. Depends on hhd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "hpack_huffman_decoder_top_defines.svh"

module hhd_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hhd_pkg::hhd_status_t st,
    output hhd_pkg::hhd_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_STEP  = 4'b0010,
        S_TERM  = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   term_ok_reg, term_ok_next;
    logic   stall;

    assign in_ready = (state_reg == S_IDLE);

    // a new pending result may only push the old one out when the output is free
    assign stall = st.pend_valid && !st.out_free;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        term_ok_next = term_ok_reg;
        cmd          = '0;
        cmd.pend_sel = hhd_pkg::PEND_LEAF;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (st.discarding)
                    begin
                        cmd.drop_byte = 1'b1;
                    end
                    else
                    begin
                        cmd.load_byte = 1'b1;
                        state_next    = S_STEP;
                    end
                end
            end
            S_STEP:
            begin
                if (!(st.leaf && stall))
                begin
                    cmd.advance = 1'b1;
                    if (st.leaf)
                    begin
                        cmd.load_pend = 1'b1;
                        if (st.eos)
                        begin
                            cmd.set_disc = !st.fin;
                            state_next   = S_FLUSH;
                        end
                        else if (st.fin && st.rest_ones)
                        begin
                            term_ok_next = 1'b1;
                            state_next   = S_TERM;
                        end
                        else if (st.last_bit)
                        begin
                            state_next = S_FLUSH;
                        end
                    end
                    else if (st.last_bit)
                    begin
                        term_ok_next = 1'b0;
                        state_next   = st.fin ? S_TERM : S_FLUSH;
                    end
                end
            end
            S_TERM:
            begin
                cmd.node_clr = 1'b1;
                if (!stall)
                begin
                    cmd.load_pend = 1'b1;
                    cmd.pend_sel  = term_ok_reg ? hhd_pkg::PEND_OK : hhd_pkg::PEND_TRUNC;
                    state_next    = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!st.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (st.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            term_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            term_ok_reg <= term_ok_next;
        end
    end

    // checks
    `HHD_ASSERT_ALWAYS(a_no_overwrite, clk, rst_n, cmd.load_pend && st.pend_valid, st.out_free)
    `HHD_ASSERT_ALWAYS(a_flush_slot, clk, rst_n, cmd.flush, st.out_free && st.pend_valid)
    `HHD_ASSERT_NEXT(a_byte_ends, clk, rst_n, cmd.advance && st.last_bit, state_reg != S_STEP)

endmodule

/* src/hpack_huffman_decoder_top.sv */
// Sequence: a byte is taken in the idle state, then one tree lookup per bit for up to 8 bits
// (fewer when EOS or an ok end stops the byte early), then the flush state releases its
// last result (a terminate state comes first when a final byte ends ok or truncated).
// The walk takes one bit per cycle through the single tree ROM port, but holds on a leaf
// while an earlier result waits on a busy output; a discarded byte is dropped in the idle state.
// Reset (rst_n, async, active low): walk at the root, discard mode off, no result held.
`timescale 1ns / 1ps

module hpack_huffman_decoder_top
(
    input  logic      clk,
    input  logic      rst_n,
    hhd_in_if.sink    in_ch,
    hhd_out_if.source out_ch
);

    hhd_pkg::hhd_cmd_t    cmd;
    hhd_pkg::hhd_status_t st;

    // sequencer
    hhd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .st       (st),
        .cmd      (cmd)
    );

    // tree walk and result path
    hhd_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (in_ch.data_byte),
        .final_byte (in_ch.final_byte),
        .cmd        (cmd),
        .st         (st),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .symbol     (out_ch.symbol),
        .status     (out_ch.status),
        .run_end    (out_ch.run_end)
    );

endmodule
